// ===== rtl/trf_pkg.sv =====
// ----------------------------------------------------------------------------
// trf_pkg
// Shared types and constants of the triangle tangent frame block.
// ----------------------------------------------------------------------------
package trf_pkg;

    localparam int TRF_QUEUE_DEPTH = 2;
    localparam int IN_DATA_W       = 160;
    localparam int OUT_DATA_W      = 96;
    localparam int OUT_USER_W      = 2;
    localparam int DELTA_W         = 33;

    // one complete triangle: edge and texture deltas
    typedef struct packed {
        logic [2:0][DELTA_W-1:0] dp0;
        logic [2:0][DELTA_W-1:0] dp1;
        logic [DELTA_W-1:0]      du0;
        logic [DELTA_W-1:0]      dv0;
        logic [DELTA_W-1:0]      du1;
        logic [DELTA_W-1:0]      dv1;
    } trf_job_t;

endpackage

// ===== rtl/trf_front.sv =====
// ----------------------------------------------------------------------------
// trf_front
// Accepts vertices, applies the v flip, holds the first two vertices and
// pushes the edge and texture deltas of each completed triangle into the queue.
// ----------------------------------------------------------------------------
module trf_front
    import trf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 q_full,
    output logic                 push,
    output trf_job_t             push_data
);

    localparam logic [1:0] SLOT_LAST = 2'd2;

    logic        flip_reg;
    logic [1:0]  slot_reg;
    logic [31:0] hp_reg [2][3];
    logic [31:0] hu_reg [2];
    logic [31:0] hv_reg [2];

    logic              accept;
    logic [31:0]       pos [3];
    logic [31:0]       tex_u;
    logic [31:0]       v_raw;
    logic [31:0]       v_eff;
    logic signed [32:0] flipped;

    function automatic logic [DELTA_W-1:0] sub33(input logic [31:0] a, input logic [31:0] b);
        sub33 = {a[31], a} - {b[31], b};
    endfunction

    assign s_tready = (slot_reg != SLOT_LAST) || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (slot_reg == SLOT_LAST);

    always_comb
    begin
        pos[0]  = s_tdata[31:0];
        pos[1]  = s_tdata[63:32];
        pos[2]  = s_tdata[95:64];
        tex_u   = s_tdata[127:96];
        v_raw   = s_tdata[159:128];
        flipped = 33'sd65536 - $signed({v_raw[31], v_raw});
        if (!flip_reg)
            v_eff = v_raw;
        else if (flipped > 33'sh07FFFFFFF)
            v_eff = 32'h7FFFFFFF;
        else
            v_eff = flipped[31:0];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            push_data.dp0[i] = sub33(hp_reg[1][i], hp_reg[0][i]);
            push_data.dp1[i] = sub33(pos[i], hp_reg[0][i]);
        end
        push_data.du0 = sub33(hu_reg[1], hu_reg[0]);
        push_data.dv0 = sub33(hv_reg[1], hv_reg[0]);
        push_data.du1 = sub33(tex_u, hu_reg[0]);
        push_data.dv1 = sub33(v_eff, hv_reg[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg <= 1'b0;
            slot_reg <= 2'd0;
        end
        else
        begin
            if (cfg_we)
                flip_reg <= cfg_wdata;
            if (accept)
                slot_reg <= (slot_reg == SLOT_LAST) ? 2'd0 : slot_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (slot_reg != SLOT_LAST))
        begin
            for (int i = 0; i < 3; i++)
                hp_reg[slot_reg[0]][i] <= pos[i];
            hu_reg[slot_reg[0]] <= tex_u;
            hv_reg[slot_reg[0]] <= v_eff;
        end
    end

endmodule

// ===== rtl/trf_queue.sv =====
// ----------------------------------------------------------------------------
// trf_queue
// Small FIFO of triangle requests between front and back.
// ----------------------------------------------------------------------------
module trf_queue
    import trf_pkg::*;
#(
    parameter int DEPTH = TRF_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  trf_job_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output trf_job_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    trf_job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue push lost");
    a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");
`endif

endmodule

// ===== rtl/trf_back.sv =====
// ----------------------------------------------------------------------------
// trf_back
// Sequencer on one shared multiplier: determinant and cross terms, then
// per-vector normalization, squares, integer square root, rounding divide.
// ----------------------------------------------------------------------------
module trf_back
    import trf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  trf_job_t              q_head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_MUL  = 10'b0000000010,
        ST_ACC  = 10'b0000000100,
        ST_NORM = 10'b0000001000,
        ST_SQM  = 10'b0000010000,
        ST_SQA  = 10'b0000100000,
        ST_SQRT = 10'b0001000000,
        ST_DSET = 10'b0010000000,
        ST_DIV  = 10'b0100000000,
        ST_OUT  = 10'b1000000000
    } state_t;

    localparam logic [3:0] TERM_LAST = 4'd13;

    state_t              state_reg;
    trf_job_t            job_reg;
    logic [3:0]          term_reg;
    logic signed [65:0]  prod_reg;
    logic signed [66:0]  acc_reg;
    logic signed [66:0]  vec_reg [6];
    logic                det_neg_reg;
    logic                deg_reg;
    logic                vsel_reg;
    logic [66:0]         c_reg [3];
    logic [2:0]          neg_reg;
    logic [62:0]         sum_reg;
    logic [4:0]          cnt_reg;
    logic [62:0]         x_reg;
    logic [62:0]         root_reg;
    logic [1:0]          comp_reg;
    logic [3:0]          k_reg;
    logic [44:0]         num_reg;
    logic [14:0]         q_reg;
    logic [15:0]         res_reg [6];
    logic                zl_reg;
    logic                m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_USER_W-1:0] m_user_reg;

    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  prod_next;
    logic [2:0]          pair;
    logic signed [66:0]  prod_ext;
    logic signed [66:0]  diff;
    logic [66:0]         or_all;
    logic [62:0]         sq_bit;
    logic [62:0]         sq_try;
    logic [44:0]         div_d;
    logic [14:0]         q_new;
    logic                out_free;
    logic [2:0]          res_idx;

    assign pair     = term_reg[3:1];
    assign prod_ext = {prod_reg[65], prod_reg};
    assign diff     = acc_reg - prod_ext;
    assign or_all   = c_reg[0] | c_reg[1] | c_reg[2];
    assign sq_bit   = 63'(1) << {cnt_reg, 1'b0};
    assign sq_try   = root_reg + sq_bit;
    assign div_d    = 45'(root_reg[30:0]) << k_reg;
    assign q_new    = (num_reg >= div_d) ? (q_reg | (15'd1 << k_reg)) : q_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && q_not_empty;
    assign res_idx  = vsel_reg ? 3'd3 + 3'(comp_reg) : 3'(comp_reg);
    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        mul_a = $signed({1'b0, c_reg[cnt_reg[1:0]][31:0]});
        mul_b = mul_a;
        if (state_reg == ST_MUL)
        begin
            case (pair)
                3'd0:
                begin
                    mul_a = $signed(term_reg[0] ? job_reg.dv0 : job_reg.du0);
                    mul_b = $signed(term_reg[0] ? job_reg.du1 : job_reg.dv1);
                end
                3'd1, 3'd2, 3'd3:
                begin
                    mul_a = $signed(term_reg[0] ? job_reg.dp1[pair - 3'd1]
                                                : job_reg.dp0[pair - 3'd1]);
                    mul_b = $signed(term_reg[0] ? job_reg.dv0 : job_reg.dv1);
                end
                default:
                begin
                    mul_a = $signed(term_reg[0] ? job_reg.dp0[pair[1:0] - 2'd0]
                                                : job_reg.dp1[pair[1:0] - 2'd0]);
                    mul_b = $signed(term_reg[0] ? job_reg.du1 : job_reg.du0);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_OUT) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (q_not_empty)
                        state_reg <= ST_MUL;
                ST_MUL:
                    state_reg <= ST_ACC;
                ST_ACC:
                    state_reg <= (term_reg == TERM_LAST) ? ST_NORM : ST_MUL;
                ST_NORM:
                    if (or_all == '0)
                        state_reg <= vsel_reg ? ST_OUT : ST_NORM;
                    else if ((or_all[66:30] == '0) && or_all[29])
                        state_reg <= ST_SQM;
                ST_SQM:
                    state_reg <= ST_SQA;
                ST_SQA:
                    state_reg <= (cnt_reg == 5'd2) ? ST_SQRT : ST_SQM;
                ST_SQRT:
                    if (cnt_reg == '0)
                        state_reg <= ST_DSET;
                ST_DSET:
                    state_reg <= ST_DIV;
                ST_DIV:
                    if (k_reg == '0)
                    begin
                        if (comp_reg != 2'd2)
                            state_reg <= ST_DSET;
                        else
                            state_reg <= vsel_reg ? ST_OUT : ST_NORM;
                    end
                ST_OUT:
                    if (out_free)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (state_reg)
            ST_IDLE:
            begin
                job_reg  <= q_head;
                term_reg <= '0;
                deg_reg  <= 1'b0;
                zl_reg   <= 1'b0;
                vsel_reg <= 1'b0;
            end
            ST_ACC:
            begin
                term_reg <= term_reg + 4'd1;
                if (!term_reg[0])
                    acc_reg <= prod_ext;
                else if (pair == 3'd0)
                begin
                    if (diff == '0)
                    begin
                        deg_reg     <= 1'b1;
                        det_neg_reg <= 1'b0;
                        job_reg.du0 <= 33'd1;
                        job_reg.dv0 <= 33'd0;
                        job_reg.du1 <= 33'd0;
                        job_reg.dv1 <= 33'd1;
                    end
                    else
                        det_neg_reg <= diff[66];
                end
                else
                    vec_reg[pair - 3'd1] <= det_neg_reg ? -diff : diff;
                if (term_reg == TERM_LAST)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        c_reg[i]   <= vec_reg[i][66] ? 67'(-vec_reg[i]) : 67'(vec_reg[i]);
                        neg_reg[i] <= vec_reg[i][66];
                    end
                    // bitangent z is the value produced this cycle
                end
            end
            ST_NORM:
            begin
                cnt_reg  <= '0;
                sum_reg  <= '0;
                comp_reg <= '0;
                if (or_all == '0)
                begin
                    zl_reg <= 1'b1;
                    for (int i = 0; i < 3; i++)
                        res_reg[vsel_reg ? 3 + i : i] <= '0;
                    vsel_reg <= 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        c_reg[i]   <= vec_reg[3+i][66] ? 67'(-vec_reg[3+i]) : 67'(vec_reg[3+i]);
                        neg_reg[i] <= vec_reg[3+i][66];
                    end
                end
                else if (or_all[66:30] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        c_reg[i] <= c_reg[i] >> 1;
                end
                else if (!or_all[29])
                begin
                    for (int i = 0; i < 3; i++)
                        c_reg[i] <= c_reg[i] << 1;
                end
            end
            ST_SQA:
            begin
                if (cnt_reg == 5'd2)
                begin
                    x_reg    <= sum_reg + 63'(prod_reg[61:0]);
                    root_reg <= '0;
                    cnt_reg  <= 5'd31;
                end
                else
                begin
                    sum_reg <= sum_reg + 63'(prod_reg[61:0]);
                    cnt_reg <= cnt_reg + 5'd1;
                end
            end
            ST_SQRT:
            begin
                if (x_reg >= sq_try)
                begin
                    x_reg    <= x_reg - sq_try;
                    root_reg <= (root_reg >> 1) + sq_bit;
                end
                else
                    root_reg <= root_reg >> 1;
                cnt_reg <= cnt_reg - 5'd1;
            end
            ST_DSET:
            begin
                num_reg <= {c_reg[comp_reg][30:0], 14'd0} + 45'(root_reg[31:1]);
                q_reg   <= '0;
                k_reg   <= 4'd14;
            end
            ST_DIV:
            begin
                if (num_reg >= div_d)
                    num_reg <= num_reg - div_d;
                q_reg <= q_new;
                k_reg <= k_reg - 4'd1;
                if (k_reg == '0)
                begin
                    res_reg[res_idx] <= neg_reg[comp_reg] ? -{1'b0, q_new} : {1'b0, q_new};
                    comp_reg <= comp_reg + 2'd1;
                    if (comp_reg == 2'd2 && !vsel_reg)
                    begin
                        vsel_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            c_reg[i]   <= vec_reg[3+i][66] ? 67'(-vec_reg[3+i])
                                                           : 67'(vec_reg[3+i]);
                            neg_reg[i] <= vec_reg[3+i][66];
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_data_reg <= {res_reg[5], res_reg[4], res_reg[3],
                                   res_reg[2], res_reg[1], res_reg[0]};
                    m_user_reg <= {zl_reg, deg_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== rtl/triangle_tangent_frame.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_frame
// Per-triangle unit tangent and bitangent from a stream of vertices.
// ----------------------------------------------------------------------------
// Every third vertex completes a triangle and produces one result; the first
// two are only held. A completed triangle sits in a two-entry request queue
// while the back end works on it, so the input keeps flowing until two
// triangles are waiting. The back end is a sequencer around one 33x33
// multiplier: it takes the request and works out the determinant and cross
// terms, then per vector runs normalization shifts, sums the squares, takes
// the square root and does a rounding divide of each of the three components
// (a zero-length vector skips these steps), and finally loads the output
// register. The v flip register affects vertices accepted after the write.
module triangle_tangent_frame
    import trf_pkg::*;
#(
    parameter int QUEUE_DEPTH = TRF_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,    // flip_v
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,      // pos_x, pos_y, pos_z, tex_u, tex_v
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,      // tangent_x/y/z, bitangent_x/y/z
    output logic [OUT_USER_W-1:0] m_tuser       // uv_degenerate, zero_length
);

    logic     q_full;
    logic     push;
    trf_job_t push_data;
    logic     pop;
    logic     q_not_empty;
    trf_job_t q_head;

    trf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    trf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_data (q_head)
    );

    trf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== verif/trf_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trf_checker
// Watches the vertex, result and register channels of the tangent frame block,
// works out the expected tangent frame of every completed triangle and
// compares each result, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module trf_checker
    import trf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [OUT_USER_W-1:0] m_tuser,
    output int                    errors,
    output int                    pending
);

    typedef logic signed [79:0] wide_t;

    typedef struct packed {
        logic [OUT_USER_W-1:0] flags;
        logic [OUT_DATA_W-1:0] frame;
    } frame_t;

    frame_t      frame_q[$];
    logic [1:0]  slot;
    logic        flip;
    wide_t       held_p[6];
    wide_t       held_u[2];
    wide_t       held_v[2];
    int          reports;

    assign pending = frame_q.size();

    // returns {zero_length, z, y, x}
    function automatic logic [48:0] unit_vec(input wide_t a, input wide_t b, input wide_t c);
        wide_t       v[3];
        logic [79:0] m[3];
        logic [63:0] cs[3];
        logic [63:0] sum, root, t, q;
        logic [47:0] o;
        int          bl;
        v[0] = a; v[1] = b; v[2] = c;
        bl = 0;
        sum = 0;
        o = '0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            for (int k = 0; k < 80; k++)
                if (m[i][k] && k + 1 > bl) bl = k + 1;
        end
        if (bl == 0) return {1'b1, 48'd0};
        for (int i = 0; i < 3; i++)
        begin
            if (bl > 30) cs[i] = 64'(m[i] >> (bl - 30));
            else cs[i] = 64'(m[i] << (30 - bl));
            sum += cs[i] * cs[i];
        end
        root = 0;
        for (int k = 31; k >= 0; k--)
        begin
            t = root | (64'd1 << k);
            if (t * t <= sum) root = t;
        end
        for (int i = 0; i < 3; i++)
        begin
            q = (cs[i] * 64'd16384 + root / 2) / root;
            if (v[i] < 0) q = -q;
            o[16*i +: 16] = q[15:0];
        end
        return {1'b0, o};
    endfunction

    function automatic frame_t tangent_frame(input wide_t px, input wide_t py,
                                             input wide_t pz, input wide_t u,
                                             input wide_t v);
        wide_t       dp0[3], dp1[3], tn[3], bt[3];
        wide_t       du0, dv0, du1, dv1, det;
        logic [48:0] ta, bi;
        logic        degen;
        frame_t      f;
        dp1[0] = px - held_p[0];
        dp1[1] = py - held_p[1];
        dp1[2] = pz - held_p[2];
        for (int i = 0; i < 3; i++) dp0[i] = held_p[3 + i] - held_p[i];
        du0 = held_u[1] - held_u[0];
        dv0 = held_v[1] - held_v[0];
        du1 = u - held_u[0];
        dv1 = v - held_v[0];
        det = du0 * dv1 - dv0 * du1;
        degen = (det == 0);
        if (degen)
        begin
            du0 = 1; dv0 = 0; du1 = 0; dv1 = 1;
        end
        for (int i = 0; i < 3; i++)
        begin
            tn[i] = dp0[i] * dv1 - dp1[i] * dv0;
            bt[i] = dp1[i] * du0 - dp0[i] * du1;
            if (det < 0)
            begin
                tn[i] = -tn[i];
                bt[i] = -bt[i];
            end
        end
        ta = unit_vec(tn[0], tn[1], tn[2]);
        bi = unit_vec(bt[0], bt[1], bt[2]);
        f.frame = {bi[47:0], ta[47:0]};
        f.flags = {ta[48] | bi[48], degen};
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wide_t  px, py, pz, u, v;
        frame_t exp_f;
        if (!rst_n)
        begin
            slot <= 0;
            flip <= 0;
            errors <= 0;
            reports = 0;
            frame_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                px = wide_t'($signed(s_tdata[31:0]));
                py = wide_t'($signed(s_tdata[63:32]));
                pz = wide_t'($signed(s_tdata[95:64]));
                u  = wide_t'($signed(s_tdata[127:96]));
                v  = wide_t'($signed(s_tdata[159:128]));
                if (flip)
                begin
                    v = 65536 - v;
                    if (v > 2147483647) v = 2147483647;
                end
                if (slot < 2)
                begin
                    held_p[slot*3]     <= px;
                    held_p[slot*3 + 1] <= py;
                    held_p[slot*3 + 2] <= pz;
                    held_u[slot[0]]    <= u;
                    held_v[slot[0]]    <= v;
                    slot <= slot + 1;
                end
                else
                begin
                    frame_q.insert(frame_q.size(), tangent_frame(px, py, pz, u, v));
                    slot <= 0;
                end
            end
            if (cfg_we) flip <= cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                if (frame_q.size() == 0)
                begin
                    errors <= errors + 1;
                    $display("%0t: result with none expected: tdata %h tuser %b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    exp_f = frame_q.pop_front();
                    if (exp_f.frame !== m_tdata || exp_f.flags !== m_tuser)
                    begin
                        errors <= errors + 1;
                        for (int i = 0; i < 6 && reports < 40; i++)
                            if (exp_f.frame[16*i +: 16] !== m_tdata[16*i +: 16])
                            begin
                                reports++;
                                $display("%0t: vector field %0d expected %0d actual %0d",
                                         $time, i, $signed(exp_f.frame[16*i +: 16]),
                                         $signed(m_tdata[16*i +: 16]));
                            end
                        if (exp_f.flags !== m_tuser && reports < 40)
                        begin
                            reports++;
                            $display("%0t: flags (zero_length, uv_degenerate) expected %b actual %b",
                                     $time, exp_f.flags, m_tuser);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== verif/triangle_tangent_frame_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_tangent_frame_tb
// Drives vertex streams through the tangent frame block: directed triangles
// for the corner cases (flipped v saturation, zero UV determinant, zero-length
// vectors, extreme coordinates) and then random triangles under random gaps
// and output stalls across v flip settings. A checker module does the scoring.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_tb;
    import trf_pkg::*;

    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam int          WATCHDOG = 6000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    int                    errors;
    int                    pending;
    int                    idle_cycles;
    bit                    burst_in;
    bit                    burst_out;

    triangle_tangent_frame dut (.*);

    trf_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [IN_DATA_W-1:0] vertex(input logic [31:0] x, input logic [31:0] y,
                                                    input logic [31:0] z, input logic [31:0] u,
                                                    input logic [31:0] v);
        return {v, u, z, y, x};
    endfunction

    function automatic logic [31:0] coord(input int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
            2: return $urandom_range(0, 1) ? MAXV : MINV;
            default: return 32'($signed($urandom_range(0, 511)) - 256) << 12;
        endcase
    endfunction

    task automatic send_vertex(input logic [IN_DATA_W-1:0] d);
        int gap;
        gap = burst_in ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic go_idle();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_flip(input logic val);
        go_idle();
        cfg_we <= 1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic random_triangle();
        logic [31:0] p[3][3], t[3][2];
        int          kind, shape;
        kind = $urandom_range(0, 3);
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++) p[i][k] = coord(kind);
            for (int k = 0; k < 2; k++) t[i][k] = coord($urandom_range(0, 3));
        end
        if (shape == 0) t[2] = t[0];
        if (shape == 1) t[1] = t[0];
        if (shape == 2) p[1] = p[0];
        if (shape == 3)
        begin
            p[1] = p[0];
            p[2] = p[0];
        end
        if (shape == 4) t[2][1] = t[0][1];
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(0, 29) == 0) burst_in = !burst_in;
            send_vertex(vertex(p[i][0], p[i][1], p[i][2], t[i][0], t[i][1]));
        end
    endtask

    // result side stalls
    initial
    begin
        int stall;
        m_tready <= 0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 29) == 0) burst_out = !burst_out;
            stall = burst_out ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                m_tready <= 0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("triangle_tangent_frame_tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 0;
        cfg_we <= 0;
        cfg_wdata <= 0;
        s_tvalid <= 0;
        s_tdata <= '0;
        burst_in = 0;
        burst_out = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // unit right triangle, then mirrored UVs for a negative determinant
        send_vertex(vertex(0, 0, 0, 0, 0));
        send_vertex(vertex(ONE, 0, 0, ONE, 0));
        send_vertex(vertex(0, ONE, 0, 0, ONE));
        send_vertex(vertex(0, 0, 0, 0, 0));
        send_vertex(vertex(ONE, 0, 0, 0, ONE));
        send_vertex(vertex(0, ONE, 0, ONE, 0));
        // zero UV determinant
        send_vertex(vertex(0, 0, ONE, 5, 7));
        send_vertex(vertex(ONE, 0, 0, 5, 7));
        send_vertex(vertex(0, ONE, 0, 5, 7));
        // zero-length tangent and bitangent
        send_vertex(vertex(ONE, ONE, ONE, 0, 0));
        send_vertex(vertex(ONE, ONE, ONE, ONE, 0));
        send_vertex(vertex(ONE, ONE, ONE, 0, ONE));
        // extreme coordinates
        send_vertex(vertex(MINV, MINV, MINV, MINV, MINV));
        send_vertex(vertex(MAXV, MAXV, MAXV, MAXV, MINV));
        send_vertex(vertex(MAXV, MINV, MAXV, MINV, MAXV));
        send_vertex(vertex(MAXV, MAXV, MAXV, MAXV, MAXV));
        send_vertex(vertex(MINV, MAXV, MINV, MINV, MAXV));
        send_vertex(vertex(MINV, MINV, MAXV, MAXV, MINV));

        // flipped v, including saturation at the negative extreme
        write_flip(1);
        send_vertex(vertex(0, 0, 0, 0, MINV));
        send_vertex(vertex(ONE, 0, 0, ONE, MAXV));
        send_vertex(vertex(0, ONE, ONE, 0, 0));
        // register change in the middle of a triangle
        send_vertex(vertex(0, 0, 0, 0, ONE));
        write_flip(0);
        send_vertex(vertex(ONE, ONE, 0, ONE, 0));
        send_vertex(vertex(0, ONE, 0, 0, MINV));

        for (int ph = 0; ph < 4; ph++)
        begin
            write_flip(ph[0]);
            for (int n = 0; n < 42; n++)
            begin
                random_triangle();
                if (ph == 1 && n == 20) go_idle();
            end
            if (ph == 2) send_vertex(vertex(coord(0), coord(0), coord(0), coord(0), coord(0)));
        end

        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("triangle_tangent_frame_tb: clean");
        else
            $display("triangle_tangent_frame_tb: errors");
        $finish;
    end

endmodule

// ===== triangle_tangent_frame.f =====
rtl/trf_pkg.sv
rtl/trf_front.sv
rtl/trf_queue.sv
rtl/trf_back.sv
rtl/triangle_tangent_frame.sv
verif/trf_checker.sv
verif/triangle_tangent_frame_tb.sv
